FILE: rtl/dss_pkg.sv
package dss_pkg;

    // Largest operand the stores hold, in digits
    localparam int DSS_MAX_DIGITS = 64;

    // Entries in the queue between front and back
    localparam int DSS_QUEUE_DEPTH = 4;

    // Decimal constants
    localparam logic [3:0] DIGIT_MAX = 4'd9;
    localparam logic [4:0] RADIX     = 5'd10;

    // Classified operation codes
    localparam logic [1:0] OP_MINUEND     = 2'd0;
    localparam logic [1:0] OP_SUBTRAHEND  = 2'd1;
    localparam logic [1:0] OP_SUB_FINAL   = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_SMALLER  = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

    // One classified transaction as it travels from front to back
    typedef struct packed {
        logic [1:0] op;
        logic [3:0] digit;
    } item_t;

endpackage

FILE: rtl/dss_ram.sv
module dss_ram #(
    parameter int WIDTH  = 4,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry into the output register
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/dss_front.sv
module dss_front
    import dss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       command,
    input  logic [3:0] digit,
    input  logic       final_digit,
    input  logic       pop,
    output logic       item_valid,
    output item_t      item
);

    localparam int PTR_W = (DSS_QUEUE_DEPTH > 1) ? $clog2(DSS_QUEUE_DEPTH) : 1;

    item_t            queue_reg [DSS_QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] wptr_next;
    logic [PTR_W-1:0] rptr_reg;
    logic [PTR_W-1:0] rptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;
    item_t            class_item;
    logic             push;
    logic             do_pop;

    // Classify the incoming transaction and clamp the digit
    always_comb
    begin
        class_item.digit = (digit > DIGIT_MAX) ? DIGIT_MAX : digit;
        if (!command)
        begin
            class_item.op = OP_MINUEND;
        end
        else if (final_digit)
        begin
            class_item.op = OP_SUB_FINAL;
        end
        else
        begin
            class_item.op = OP_SUBTRAHEND;
        end
    end

    assign busy       = (count_reg == (PTR_W+1)'(DSS_QUEUE_DEPTH));
    assign push       = start && !busy;
    assign item_valid = (count_reg != '0);
    assign do_pop     = pop && item_valid;
    assign item       = queue_reg[rptr_reg];

    // Advance the queue pointers and fill count
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PTR_W'(DSS_QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(DSS_QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Hold the queued payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wptr_reg] <= class_item;
        end
    end

endmodule

FILE: rtl/dss_back.sv
module dss_back
    import dss_pkg::*;
#(
    parameter int MAX_DIGITS = DSS_MAX_DIGITS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  item_t      item,
    output logic       pop,
    output logic       done,
    output logic [3:0] result_digit,
    output logic       result_last,
    output logic [1:0] status
);

    localparam int ADDR_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int LEN_W  = $clog2(MAX_DIGITS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SUB  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [LEN_W-1:0] mlen_reg, mlen_next;
    logic [LEN_W-1:0] slen_reg, slen_next;
    logic             tl_reg, tl_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic             pend_reg, pend_next;
    logic [LEN_W-1:0] pidx_reg, pidx_next;
    logic             plast_reg, plast_next;
    logic             borrow_reg, borrow_next;
    logic [LEN_W-1:0] top_reg, top_next;
    logic [LEN_W-1:0] ecnt_reg, ecnt_next;
    logic             done_reg, done_next;
    logic [3:0]       digit_reg, digit_next;
    logic             last_reg, last_next;
    logic [1:0]       status_reg, status_next;

    logic              m_we, s_we, d_we;
    logic [ADDR_W-1:0] m_waddr, s_waddr, d_waddr;
    logic [ADDR_W-1:0] m_raddr, s_raddr, d_raddr;
    logic [3:0]        m_rdata, s_rdata, d_rdata, d_wdata;

    logic [LEN_W-1:0] n_len;
    logic [LEN_W-1:0] m_pos, s_pos, e_pos;
    logic             issue;
    logic [3:0]       da, db;
    logic [4:0]       sub_val;
    logic [4:0]       diff_val;

    dss_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS), .ADDR_W(ADDR_W)) u_minuend_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (item.digit),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    dss_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS), .ADDR_W(ADDR_W)) u_subtrahend_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (item.digit),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    dss_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS), .ADDR_W(ADDR_W)) u_diff_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    // Longer operand length and the read positions, least significant first
    assign n_len   = (mlen_reg > slen_reg) ? mlen_reg : slen_reg;
    assign m_pos   = mlen_reg - 1'b1 - idx_reg;
    assign s_pos   = slen_reg - 1'b1 - idx_reg;
    assign e_pos   = ecnt_reg - 1'b1;
    assign m_raddr = m_pos[ADDR_W-1:0];
    assign s_raddr = s_pos[ADDR_W-1:0];
    assign d_raddr = e_pos[ADDR_W-1:0];
    assign m_waddr = mlen_reg[ADDR_W-1:0];
    assign s_waddr = slen_reg[ADDR_W-1:0];
    assign d_waddr = pidx_reg[ADDR_W-1:0];

    // Borrow step on the digit pair that the stores returned
    always_comb
    begin
        da      = (pidx_reg < mlen_reg) ? m_rdata : 4'd0;
        db      = (pidx_reg < slen_reg) ? s_rdata : 4'd0;
        sub_val = {1'b0, db} + {4'd0, borrow_reg};
        if ({1'b0, da} >= sub_val)
        begin
            diff_val = {1'b0, da} - sub_val;
        end
        else
        begin
            diff_val = {1'b0, da} + RADIX - sub_val;
        end
    end

    assign d_wdata = diff_val[3:0];

    // Sequence load, subtract and emit passes
    always_comb
    begin
        state_next  = state_reg;
        mlen_next   = mlen_reg;
        slen_next   = slen_reg;
        tl_next     = tl_reg;
        idx_next    = idx_reg;
        pend_next   = 1'b0;
        pidx_next   = pidx_reg;
        plast_next  = plast_reg;
        borrow_next = borrow_reg;
        top_next    = top_reg;
        ecnt_next   = ecnt_reg;
        done_next   = 1'b0;
        digit_next  = digit_reg;
        last_next   = last_reg;
        status_next = status_reg;
        pop         = 1'b0;
        m_we        = 1'b0;
        s_we        = 1'b0;
        d_we        = 1'b0;
        issue       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                pop = item_valid;
                if (item_valid)
                begin
                    if (item.op == OP_MINUEND)
                    begin
                        if (mlen_reg < LEN_W'(MAX_DIGITS))
                        begin
                            m_we      = 1'b1;
                            mlen_next = mlen_reg + 1'b1;
                        end
                        else
                        begin
                            tl_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (slen_reg < LEN_W'(MAX_DIGITS))
                        begin
                            s_we      = 1'b1;
                            slen_next = slen_reg + 1'b1;
                        end
                        else
                        begin
                            tl_next = 1'b1;
                        end
                        if (item.op == OP_SUB_FINAL)
                        begin
                            if (tl_next)
                            begin
                                done_next   = 1'b1;
                                digit_next  = 4'd0;
                                last_next   = 1'b1;
                                status_next = STATUS_TOO_LONG;
                                mlen_next   = '0;
                                slen_next   = '0;
                                tl_next     = 1'b0;
                            end
                            else
                            begin
                                state_next  = S_SUB;
                                idx_next    = '0;
                                borrow_next = 1'b0;
                                top_next    = '0;
                            end
                        end
                    end
                end
            end

            S_SUB:
            begin
                issue = (idx_reg < n_len);
                if (issue)
                begin
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                    pidx_next = idx_reg;
                end
                if (pend_reg)
                begin
                    d_we        = 1'b1;
                    borrow_next = ({1'b0, da} < sub_val);
                    if (diff_val != 5'd0)
                    begin
                        top_next = pidx_reg + 1'b1;
                    end
                end
                if (!issue && !pend_reg)
                begin
                    mlen_next = '0;
                    slen_next = '0;
                    tl_next   = 1'b0;
                    if (borrow_reg || top_reg == '0)
                    begin
                        state_next  = S_IDLE;
                        done_next   = 1'b1;
                        digit_next  = 4'd0;
                        last_next   = 1'b1;
                        status_next = borrow_reg ? STATUS_SMALLER : STATUS_OK;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                        ecnt_next  = top_reg;
                    end
                end
            end

            S_EMIT:
            begin
                issue = (ecnt_reg != '0);
                if (issue)
                begin
                    ecnt_next  = ecnt_reg - 1'b1;
                    pend_next  = 1'b1;
                    plast_next = (ecnt_reg == LEN_W'(1));
                end
                if (pend_reg)
                begin
                    done_next   = 1'b1;
                    digit_next  = d_rdata;
                    last_next   = plast_reg;
                    status_next = STATUS_OK;
                end
                if (!issue && !pend_reg)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mlen_reg  <= '0;
            slen_reg  <= '0;
            tl_reg    <= 1'b0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mlen_reg  <= mlen_next;
            slen_reg  <= slen_next;
            tl_reg    <= tl_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // Hold pass counters and result payload
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pidx_reg   <= pidx_next;
        plast_reg  <= plast_next;
        borrow_reg <= borrow_next;
        top_reg    <= top_next;
        ecnt_reg   <= ecnt_next;
        digit_reg  <= digit_next;
        last_reg   <= last_next;
        status_reg <= status_next;
    end

    assign done         = done_reg;
    assign result_digit = digit_reg;
    assign result_last  = last_reg;
    assign status       = status_reg;

endmodule

FILE: rtl/decimal_string_subtractor.sv
// Channel   Direction  Handshake                 Payload
// input     in         start & !busy             command, digit, final_digit
// result    out        done, one cycle, no stall result_digit, result_last, status
//
// Digit transactions are taken one per cycle, while busy is low, into a
// four-entry queue; the back end pops and stores digits only while idle. A
// subtrahend final digit starts a borrow pass over the digit stores, then an
// emit pass reading the difference store; a smaller or zero result ends the
// borrow pass with no emit pass, and a too-long result comes out the cycle
// after its final digit reaches the back end.
// busy rises only while the queue is full.
// Reset clears lengths, flags and the queue; the stores need no clearing.
module decimal_string_subtractor
    import dss_pkg::*;
#(
    parameter int MAX_DIGITS = DSS_MAX_DIGITS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       command,
    input  logic [3:0] digit,
    input  logic       final_digit,
    output logic       done,
    output logic [3:0] result_digit,
    output logic       result_last,
    output logic [1:0] status
);

    item_t q_item;
    logic  q_valid;
    logic  q_pop;

    dss_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .digit       (digit),
        .final_digit (final_digit),
        .pop         (q_pop),
        .item_valid  (q_valid),
        .item        (q_item)
    );

    dss_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (q_valid),
        .item         (q_item),
        .pop          (q_pop),
        .done         (done),
        .result_digit (result_digit),
        .result_last  (result_last),
        .status       (status)
    );

endmodule

FILE: tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dss_pkg::*;

    // Command encoding on the one-bit port
    localparam logic CMD_MINUEND    = 1'b0;
    localparam logic CMD_SUBTRAHEND = 1'b1;

    // Cycles to wait after the last expected result
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        logic       command;
        logic [3:0] digit;
        logic       final_digit;
        int         idle_pct;
    } digit_txn_t;

    typedef struct {
        logic [3:0] digit;
        logic       last;
        logic [1:0] status;
    } diff_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic       command = CMD_MINUEND;
    logic [3:0] digit = 4'd0;
    logic       final_digit = 1'b0;
    logic       done;
    logic [3:0] result_digit;
    logic       result_last;
    logic [1:0] status;

    digit_txn_t   pending_digits[$];
    diff_result_t expected_diffs[$];
    int           error_count = 0;
    int           sender_idle_pct = 0;
    int           queued_count = 0;

    // Predictor state: operand stores, lengths and the overflow flag
    logic [3:0] minuend_mem[DSS_MAX_DIGITS];
    logic [3:0] subtrahend_mem[DSS_MAX_DIGITS];
    int         minuend_len = 0;
    int         subtrahend_len = 0;
    logic       overflow_seen = 1'b0;

    decimal_string_subtractor dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .digit        (digit),
        .final_digit  (final_digit),
        .done         (done),
        .result_digit (result_digit),
        .result_last  (result_last),
        .status       (status)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Update the operand stores and queue the results one digit causes
    task automatic predict_difference(input logic cmd, input logic [3:0] dig,
                                      input logic fin);
        logic [3:0]   stored;
        logic [3:0]   diff_digits[DSS_MAX_DIGITS];
        int           span;
        int           top;
        int           i;
        int           da;
        int           db;
        int           need;
        logic         borrow;
        diff_result_t res;
        stored = (dig > DIGIT_MAX) ? DIGIT_MAX : dig;
        if (cmd == CMD_MINUEND)
        begin
            if (minuend_len < DSS_MAX_DIGITS)
            begin
                minuend_mem[minuend_len] = stored;
                minuend_len++;
            end
            else
                overflow_seen = 1'b1;
            return;
        end
        if (subtrahend_len < DSS_MAX_DIGITS)
        begin
            subtrahend_mem[subtrahend_len] = stored;
            subtrahend_len++;
        end
        else
            overflow_seen = 1'b1;
        if (!fin)
            return;

        res.digit = 4'd0;
        res.last = 1'b1;
        res.status = STATUS_OK;
        if (overflow_seen)
        begin
            res.status = STATUS_TOO_LONG;
            expected_diffs.push_back(res);
        end
        else
        begin
            // Borrow subtraction, least significant digit first
            span = (minuend_len > subtrahend_len) ? minuend_len : subtrahend_len;
            borrow = 1'b0;
            for (i = 0; i < span; i++)
            begin
                da = (i < minuend_len) ? int'(minuend_mem[minuend_len - 1 - i]) : 0;
                db = (i < subtrahend_len) ? int'(subtrahend_mem[subtrahend_len - 1 - i]) : 0;
                need = db + int'(borrow);
                if (da >= need)
                begin
                    diff_digits[i] = 4'(da - need);
                    borrow = 1'b0;
                end
                else
                begin
                    diff_digits[i] = 4'(da + int'(RADIX) - need);
                    borrow = 1'b1;
                end
            end
            top = 0;
            for (i = 0; i < span; i++)
                if (diff_digits[i] != 4'd0)
                    top = i + 1;
            if (borrow)
            begin
                res.status = STATUS_SMALLER;
                expected_diffs.push_back(res);
            end
            else if (top == 0)
                expected_diffs.push_back(res);
            else
            begin
                // Emit most significant first, leading zeros dropped
                for (i = top - 1; i >= 0; i--)
                begin
                    res.digit = diff_digits[i];
                    res.last = (i == 0);
                    expected_diffs.push_back(res);
                end
            end
        end
        minuend_len = 0;
        subtrahend_len = 0;
        overflow_seen = 1'b0;
    endtask

    task automatic add_digit(input logic cmd, input logic [3:0] dig, input logic fin);
        digit_txn_t txn;
        txn.command = cmd;
        txn.digit = dig;
        txn.final_digit = fin;
        txn.idle_pct = sender_idle_pct;
        pending_digits.push_back(txn);
        queued_count++;
    endtask

    // Queue a decimal number as one operand, final mark on its last digit
    task automatic queue_number(input logic cmd, input longint unsigned value);
        logic [3:0] digs[20];
        int         n;
        int         i;
        n = 0;
        do
        begin
            digs[n] = 4'(value % RADIX);
            value = value / RADIX;
            n++;
        end
        while (value != 0);
        for (i = n - 1; i >= 0; i--)
            add_digit(cmd, digs[i], i == 0);
    endtask

    // Queue count copies of one digit, final mark on the last
    task automatic queue_run(input logic cmd, input logic [3:0] dig, input int count);
        int i;
        for (i = 0; i < count; i++)
            add_digit(cmd, dig, i == count - 1);
    endtask

    function automatic logic [3:0] rand_digit();
        if ($urandom_range(99) < 10)
            return 4'($urandom_range(15, 10));
        return 4'($urandom_range(9));
    endfunction

    // Drive digit transactions from the pending queue
    always @(posedge clk or negedge rst_n)
    begin : drive
        digit_txn_t txn;
        if (!rst_n)
        begin
            start <= 1'b0;
            command <= CMD_MINUEND;
            digit <= 4'd0;
            final_digit <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_difference(command, digit, final_digit);
                void'(pending_digits.pop_front());
            end
            // Hold the current transaction while the block is busy
            if (!(start && busy))
            begin
                if (pending_digits.size() > 0 &&
                    $urandom_range(99) >= pending_digits[0].idle_pct)
                begin
                    txn = pending_digits[0];
                    start <= 1'b1;
                    command <= txn.command;
                    digit <= txn.digit;
                    final_digit <= txn.final_digit;
                end
                else
                begin
                    start <= 1'b0;
                    command <= 1'($urandom);
                    digit <= 4'($urandom);
                    final_digit <= 1'($urandom);
                end
            end
        end
    end

    // Check each difference digit against the oldest expectation
    always @(posedge clk)
    begin : check
        diff_result_t exp_res;
        if (rst_n && done)
        begin
            if (expected_diffs.size() == 0)
            begin
                $display("%0t: unexpected result digit=%0d last=%0d status=%0d",
                         $time, result_digit, result_last, status);
                error_count++;
            end
            else
            begin
                exp_res = expected_diffs.pop_front();
                if (result_digit !== exp_res.digit)
                begin
                    $display("%0t: result_digit expected %0d actual %0d",
                             $time, exp_res.digit, result_digit);
                    error_count++;
                end
                if (result_last !== exp_res.last)
                begin
                    $display("%0t: result_last expected %0d actual %0d",
                             $time, exp_res.last, result_last);
                    error_count++;
                end
                if (status !== exp_res.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_res.status, status);
                    error_count++;
                end
            end
        end
    end

    // Fill the stimulus queue, release reset, then drain
    initial
    begin
        logic [3:0] min_digits[80];
        int         idle_plan[4];
        int         phase;
        int         phase_end;
        int         min_len;
        int         sub_len;
        int         keep;
        int         mode;
        int         i;
        int         r;

        idle_plan = '{0, 71, 0, 6};

        // Directed: plain cases
        queue_number(CMD_MINUEND, 5);
        queue_number(CMD_SUBTRAHEND, 3);
        queue_number(CMD_MINUEND, 7);
        queue_number(CMD_SUBTRAHEND, 7);
        queue_number(CMD_MINUEND, 3);
        queue_number(CMD_SUBTRAHEND, 5);
        // Leading zeros of the difference
        queue_number(CMD_MINUEND, 100);
        queue_number(CMD_SUBTRAHEND, 99);
        queue_number(CMD_MINUEND, 64'd9876543210);
        queue_number(CMD_SUBTRAHEND, 64'd123456789);
        // Digits above nine clamp to nine
        add_digit(CMD_MINUEND, 4'd15, 1'b1);
        add_digit(CMD_SUBTRAHEND, 4'd10, 1'b1);
        // Minuend final marks do not close the operand
        add_digit(CMD_MINUEND, 4'd1, 1'b1);
        add_digit(CMD_MINUEND, 4'd2, 1'b1);
        add_digit(CMD_SUBTRAHEND, 4'd2, 1'b1);
        // Subtrahend digit with no final mark
        queue_number(CMD_MINUEND, 20);
        add_digit(CMD_SUBTRAHEND, 4'd1, 1'b0);
        add_digit(CMD_SUBTRAHEND, 4'd1, 1'b1);
        // Empty minuend counts as zero
        add_digit(CMD_SUBTRAHEND, 4'd0, 1'b1);
        add_digit(CMD_SUBTRAHEND, 4'd5, 1'b1);
        // Full stores: longest difference
        queue_run(CMD_MINUEND, 4'd9, DSS_MAX_DIGITS);
        queue_number(CMD_SUBTRAHEND, 0);
        // Subtrahend overflow wins over a smaller minuend
        queue_number(CMD_MINUEND, 1);
        queue_run(CMD_SUBTRAHEND, 4'd5, DSS_MAX_DIGITS + 1);

        // Random: well-formed operand pairs with some noise
        for (phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct = idle_plan[phase];
            phase_end = queued_count + 8;
            while (queued_count < phase_end)
            begin
                r = $urandom_range(99);
                if (r < 6)
                begin
                    // Stray transactions
                    for (i = 0; i < int'($urandom_range(3, 1)); i++)
                        add_digit(1'($urandom), 4'($urandom), 1'($urandom));
                end
                else
                begin
                    if (r < 11)
                        min_len = 0;
                    else if (r < 15)
                        min_len = $urandom_range(68, 60);
                    else
                        min_len = $urandom_range(8, 1);
                    for (i = 0; i < min_len; i++)
                    begin
                        min_digits[i] = rand_digit();
                        add_digit(CMD_MINUEND, min_digits[i],
                                  (i == min_len - 1) || ($urandom_range(99) < 5));
                    end
                    mode = $urandom_range(99);
                    if (min_len > 0 && mode < 30)
                    begin
                        // Copy the upper digits to force zeros at the top
                        keep = $urandom_range(min_len);
                        for (i = 0; i < min_len; i++)
                            add_digit(CMD_SUBTRAHEND,
                                      (i < keep) ? min_digits[i] : rand_digit(),
                                      i == min_len - 1);
                    end
                    else
                    begin
                        if (mode > 96)
                            sub_len = $urandom_range(68, 60);
                        else
                            sub_len = $urandom_range((min_len > 8 ? 8 : min_len) + 1, 1);
                        for (i = 0; i < sub_len; i++)
                            add_digit(CMD_SUBTRAHEND, rand_digit(),
                                      (i == sub_len - 1) || ($urandom_range(99) < 2));
                    end
                end
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_digits.size() > 0 || expected_diffs.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
rtl/dss_pkg.sv
rtl/dss_ram.sv
rtl/dss_front.sv
rtl/dss_back.sv
rtl/decimal_string_subtractor.sv
tb/sv/tb.sv
